// ===== rtl/core/bttu_pkg.sv =====
// ----------------------------------------------------------------------------
// bttu_pkg
// Shared types, phase codes and register constants of the tick-timed 8N1
// serial transmitter and receiver.
// ----------------------------------------------------------------------------
package bttu_pkg;

    // configuration register indexes
    localparam logic CFG_BIT_TICKS     = 1'b0;
    localparam logic CFG_TIMEOUT_TICKS = 1'b1;

    // register reset values
    localparam logic [15:0] BIT_TICKS_RESET     = 16'd34;
    localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd30000;

    // receiver phases
    localparam logic [2:0] RX_IDLE   = 3'd0;
    localparam logic [2:0] RX_WAIT   = 3'd1;
    localparam logic [2:0] RX_CENTER = 3'd2;
    localparam logic [2:0] RX_DATA   = 3'd3;
    localparam logic [2:0] RX_STOP   = 3'd4;

    // transmitter phases
    localparam logic [1:0] TX_IDLE  = 2'd0;
    localparam logic [1:0] TX_START = 2'd1;
    localparam logic [1:0] TX_DATA  = 2'd2;
    localparam logic [1:0] TX_STOP  = 2'd3;

    // index of the last data bit
    localparam logic [2:0] LAST_BIT = 3'd7;

    // receiver status for one tick
    typedef struct packed {
        logic       busy;
        logic       valid;
        logic [7:0] data;
        logic       timeout;
    } t_rx_result;

    // transmitter status for one tick
    typedef struct packed {
        logic line;
        logic busy;
        logic rejected;
    } t_tx_result;

    // n - k when n exceeds k, else 1
    function automatic logic [15:0] less_or_one(input logic [15:0] n, input logic [15:0] k);
        less_or_one = (n > k) ? (n - k) : 16'd1;
    endfunction

endpackage

// ===== rtl/core/bit_timed_uart_transceiver.sv =====
// ----------------------------------------------------------------------------
// bit_timed_uart_transceiver
// Latency: a tick's result is registered and presented in the cycle after the tick is accepted.
// Throughput: one tick per cycle while i_out_ready holds; the result register frees as it is taken.
// The tick rate is set by the single pass through the receive and transmit
// state logic into the result register.
// Reset (synchronous, active low) idles both sides and restores the registers.
// ----------------------------------------------------------------------------
module bit_timed_uart_transceiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_rx_level,
    input  logic        i_read_request,
    input  logic        i_send_request,
    input  logic [7:0]  i_send_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_tx_line,
    output logic        o_tx_busy,
    output logic        o_tx_rejected,
    output logic        o_rx_busy,
    output logic        o_rx_valid,
    output logic [7:0]  o_rx_byte,
    output logic        o_rx_timeout,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]          r_bit_ticks;
    logic [15:0]          r_timeout_ticks;
    logic                 r_out_valid;
    bttu_pkg::t_rx_result r_rx_res;
    bttu_pkg::t_tx_result r_tx_res;
    bttu_pkg::t_rx_result w_rx_res;
    bttu_pkg::t_tx_result w_tx_res;
    logic                 w_step;
    logic                 w_cfg_write;

    // request flow: a tick steps when the result register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_step     = i_in_valid && o_in_ready;

    // configuration registers
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_ticks     <= bttu_pkg::BIT_TICKS_RESET;
            r_timeout_ticks <= bttu_pkg::TIMEOUT_TICKS_RESET;
        end else if (w_cfg_write) begin
            unique case (paddr[2])
                bttu_pkg::CFG_BIT_TICKS:     r_bit_ticks     <= pwdata[15:0];
                bttu_pkg::CFG_TIMEOUT_TICKS: r_timeout_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[2])
            bttu_pkg::CFG_BIT_TICKS:     prdata = {16'd0, r_bit_ticks};
            bttu_pkg::CFG_TIMEOUT_TICKS: prdata = {16'd0, r_timeout_ticks};
            default:                     prdata = 32'd0;
        endcase
    end

    bttu_rx u_rx (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_rx_level      (i_rx_level),
        .i_read_request  (i_read_request),
        .i_bit_ticks     (r_bit_ticks),
        .i_timeout_ticks (r_timeout_ticks),
        .o_result        (w_rx_res)
    );

    bttu_tx u_tx (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_send_request (i_send_request),
        .i_send_byte    (i_send_byte),
        .i_bit_ticks    (r_bit_ticks),
        .o_result       (w_tx_res)
    );

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_rx_res <= w_rx_res;
            r_tx_res <= w_tx_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tx_line     = r_tx_res.line;
    assign o_tx_busy     = r_tx_res.busy;
    assign o_tx_rejected = r_tx_res.rejected;
    assign o_rx_busy     = r_rx_res.busy;
    assign o_rx_valid    = r_rx_res.valid;
    assign o_rx_byte     = r_rx_res.data;
    assign o_rx_timeout  = r_rx_res.timeout;

endmodule

// ===== rtl/core/bttu_rx.sv =====
// ----------------------------------------------------------------------------
// bttu_rx
// Receiver: waits for a start edge with timeout, centers if bit_ticks >= 4,
// samples 8 data bits LSB first, skips the stop bit. Advances one tick per step.
// ----------------------------------------------------------------------------
module bttu_rx (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_rx_level,
    input  logic                  i_read_request,
    input  logic [15:0]           i_bit_ticks,
    input  logic [15:0]           i_timeout_ticks,
    output bttu_pkg::t_rx_result  o_result
);

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_counter, n_counter;
    logic [2:0]  r_index, n_index;
    logic [7:0]  r_shift, n_shift;
    logic        w_valid;
    logic        w_timeout;
    logic [15:0] w_dec;
    logic [15:0] w_data_wait;

    assign w_dec       = r_counter - 16'd1;
    assign w_data_wait = bttu_pkg::less_or_one(i_bit_ticks, 16'd4);

    // next state for one tick
    always_comb begin
        n_phase   = r_phase;
        n_counter = r_counter;
        n_index   = r_index;
        n_shift   = r_shift;
        w_valid   = 1'b0;
        w_timeout = 1'b0;
        unique case (r_phase)
            bttu_pkg::RX_IDLE: begin
                if (i_read_request) begin
                    n_phase   = bttu_pkg::RX_WAIT;
                    n_counter = 16'd0;
                    n_index   = 3'd0;
                    n_shift   = 8'd0;
                end
            end
            bttu_pkg::RX_WAIT: begin
                if (!i_rx_level) begin
                    if (i_bit_ticks[15:2] == 14'd0) begin
                        n_phase   = bttu_pkg::RX_DATA;
                        n_counter = w_data_wait;
                    end else begin
                        n_phase   = bttu_pkg::RX_CENTER;
                        n_counter = {2'b00, i_bit_ticks[15:2]};
                    end
                end else if (r_counter >= i_timeout_ticks) begin
                    w_timeout = 1'b1;
                    n_phase   = bttu_pkg::RX_IDLE;
                    n_counter = 16'd0;
                end else begin
                    n_counter = r_counter + 16'd1;
                end
            end
            bttu_pkg::RX_CENTER: begin
                n_counter = w_dec;
                if (w_dec == 16'd0) begin
                    n_phase   = bttu_pkg::RX_DATA;
                    n_counter = w_data_wait;
                end
            end
            bttu_pkg::RX_DATA: begin
                n_counter = w_dec;
                if (w_dec == 16'd0) begin
                    n_shift = {i_rx_level, r_shift[7:1]};
                    if (r_index == bttu_pkg::LAST_BIT) begin
                        n_index   = 3'd0;
                        n_phase   = bttu_pkg::RX_STOP;
                        n_counter = bttu_pkg::less_or_one(i_bit_ticks, 16'd2);
                    end else begin
                        n_index   = r_index + 3'd1;
                        n_counter = w_data_wait;
                    end
                end
            end
            bttu_pkg::RX_STOP: begin
                n_counter = w_dec;
                if (w_dec == 16'd0) begin
                    w_valid = 1'b1;
                    n_phase = bttu_pkg::RX_IDLE;
                end
            end
            default: begin
                n_phase   = bttu_pkg::RX_IDLE;
                n_counter = 16'd0;
            end
        endcase
    end

    // status of this tick
    assign o_result.busy    = (n_phase != bttu_pkg::RX_IDLE);
    assign o_result.valid   = w_valid;
    assign o_result.data    = w_valid ? r_shift : 8'd0;
    assign o_result.timeout = w_timeout;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= bttu_pkg::RX_IDLE;
            r_counter <= 16'd0;
            r_index   <= 3'd0;
            r_shift   <= 8'd0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_counter <= n_counter;
            r_index   <= n_index;
            r_shift   <= n_shift;
        end
    end

endmodule

// ===== rtl/core/bttu_tx.sv =====
// ----------------------------------------------------------------------------
// bttu_tx
// Transmitter: sends start bit, 8 data bits LSB first and stop bit, each
// held for a tick count set by the bit ticks register. Advances one tick per step.
// ----------------------------------------------------------------------------
module bttu_tx (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_send_request,
    input  logic [7:0]            i_send_byte,
    input  logic [15:0]           i_bit_ticks,
    output bttu_pkg::t_tx_result  o_result
);

    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_counter, n_counter;
    logic [2:0]  r_index, n_index;
    logic [7:0]  r_shift, n_shift;
    logic        w_rejected;
    logic        w_line;
    logic [15:0] w_hold;

    // extra ticks each bit is held
    assign w_hold = bttu_pkg::less_or_one(i_bit_ticks, 16'd3) - 16'd1;

    // next state for one tick
    always_comb begin
        n_phase    = r_phase;
        n_counter  = r_counter;
        n_index    = r_index;
        n_shift    = r_shift;
        w_rejected = 1'b0;
        if (r_phase == bttu_pkg::TX_IDLE) begin
            if (i_send_request) begin
                if (i_bit_ticks == 16'd0) begin
                    w_rejected = 1'b1;
                end else begin
                    n_phase   = bttu_pkg::TX_START;
                    n_counter = w_hold;
                    n_index   = 3'd0;
                    n_shift   = i_send_byte;
                end
            end
        end else if (r_counter != 16'd0) begin
            n_counter = r_counter - 16'd1;
        end else begin
            unique case (r_phase)
                bttu_pkg::TX_START: begin
                    n_phase = bttu_pkg::TX_DATA;
                    n_index = 3'd0;
                end
                bttu_pkg::TX_DATA: begin
                    n_shift = {1'b0, r_shift[7:1]};
                    if (r_index == bttu_pkg::LAST_BIT) begin
                        n_index = 3'd0;
                        n_phase = bttu_pkg::TX_STOP;
                    end else begin
                        n_index = r_index + 3'd1;
                    end
                end
                default: begin
                    n_phase = bttu_pkg::TX_IDLE;
                end
            endcase
            n_counter = (n_phase == bttu_pkg::TX_IDLE) ? 16'd0 : w_hold;
        end
    end

    // line level after this tick
    always_comb begin
        case (n_phase)
            bttu_pkg::TX_START: w_line = 1'b0;
            bttu_pkg::TX_DATA:  w_line = n_shift[0];
            default:            w_line = 1'b1;
        endcase
    end

    assign o_result.line     = w_line;
    assign o_result.busy     = (n_phase != bttu_pkg::TX_IDLE);
    assign o_result.rejected = w_rejected;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= bttu_pkg::TX_IDLE;
            r_counter <= 16'd0;
            r_index   <= 3'd0;
            r_shift   <= 8'd0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_counter <= n_counter;
            r_index   <= n_index;
            r_shift   <= n_shift;
        end
    end

endmodule
